// File: hw/rtl/gsm7_septet_packer_macros.svh
// Assertion macros used by the septet packer back end.
`ifndef GSM7_SEPTET_PACKER_MACROS_SVH
`define GSM7_SEPTET_PACKER_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define GSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define GSP_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: hw/rtl/gsp_pkg.sv
// Types, constants and the character table of the septet packer.
package gsp_pkg;

  localparam logic [6:0] EscSeptet = 7'h1B;
  localparam logic [6:0] CrSeptet  = 7'h0D;

  localparam int unsigned SeptetW = 7;
  localparam int unsigned WorkW   = 21;
  localparam int unsigned CntW    = 5;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [6:0] septet;
    logic       ext;
    logic       bad;
    logic       final_char;
  } sept_entry_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_last;
    logic       bad_char;
  } out_word_t;

  function automatic sept_entry_t classify(logic [7:0] c, logic fin);
    sept_entry_t e;
    e.septet     = c[6:0];
    e.ext        = 1'b0;
    e.bad        = 1'b0;
    e.final_char = fin;
    unique case (c) inside
      8'h40: e.septet = 7'h00;
      8'h24: e.septet = 7'h02;
      8'h0A: e.septet = 7'h0A;
      8'h5F: e.septet = 7'h11;
      8'h5E: begin e.septet = 7'h14; e.ext = 1'b1; end
      8'h7B: begin e.septet = 7'h28; e.ext = 1'b1; end
      8'h7D: begin e.septet = 7'h29; e.ext = 1'b1; end
      8'h5C: begin e.septet = 7'h2F; e.ext = 1'b1; end
      8'h5B: begin e.septet = 7'h3C; e.ext = 1'b1; end
      8'h7E: begin e.septet = 7'h3D; e.ext = 1'b1; end
      8'h5D: begin e.septet = 7'h3E; e.ext = 1'b1; end
      8'h7C: begin e.septet = 7'h40; e.ext = 1'b1; end
      [8'h20:8'h23], [8'h25:8'h3F], [8'h41:8'h5A], [8'h61:8'h7A]: e.septet = c[6:0];
      default: begin
        e.septet = '0;
        e.bad    = 1'b1;
      end
    endcase
    return e;
  endfunction

endpackage

// File: hw/rtl/gsp_front.sv
// Front end: maps each character to a septet and queues it for the packer.
module gsp_front import gsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_code_i,
  input  logic        is_final_char_i,
  output logic        entry_valid_o,
  output sept_entry_t entry_o,
  input  logic        entry_take_i
);

  sept_entry_t            mem_q [QDepth];
  logic [QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]       cnt_q, cnt_d;
  logic                   wr_en;
  logic                   rd_en;

  assign full          = (cnt_q == QCntW'(QDepth));
  assign entry_valid_o = (cnt_q != '0);
  assign entry_o       = mem_q[rd_ptr_q];
  assign wr_en         = push && !full;
  assign rd_en         = entry_take_i && entry_valid_o;

  always_comb begin
    wr_ptr_d = wr_en ? QPtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = rd_en ? QPtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = QCntW'(cnt_q + 1'b1);
    end else if (rd_en && !wr_en) begin
      cnt_d = QCntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= classify(char_code_i, is_final_char_i);
    end
  end

endmodule

// File: hw/rtl/gsp_back.sv
// Back end: packs septets into octets and holds finished words for the consumer.
`include "gsm7_septet_packer_macros.svh"

module gsp_back import gsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        entry_valid_i,
  input  sept_entry_t entry_i,
  output logic        entry_take_o,
  output logic        empty,
  input  logic        pop,
  output out_word_t   word_o
);

  logic [WorkW-1:0]     work_bits_q, work_bits_d;
  logic [CntW-1:0]      work_cnt_q, work_cnt_d;
  logic                 work_final_q, work_final_d;
  logic                 busy_q, busy_d;

  out_word_t            out_mem_q [QDepth];
  logic [QPtrW-1:0]     out_wr_q, out_wr_d;
  logic [QPtrW-1:0]     out_rd_q, out_rd_d;
  logic [QCntW-1:0]     out_cnt_q, out_cnt_d;
  logic                 out_full;
  logic                 out_push;
  logic                 out_pop;
  out_word_t            out_word;

  logic [2*SeptetW-1:0] payload;
  logic [WorkW-1:0]     merged_bits;
  logic [CntW-1:0]      merged_cnt;
  logic [CntW-1:0]      cnt_after;

  assign out_full = (out_cnt_q == QCntW'(QDepth));
  assign empty    = (out_cnt_q == '0);
  assign out_pop  = pop && !empty;
  assign word_o   = out_mem_q[out_rd_q];

  always_comb begin
    payload     = entry_i.ext ? {entry_i.septet, EscSeptet} : {7'b0, entry_i.septet};
    merged_bits = work_bits_q | (WorkW'(payload) << work_cnt_q);
    merged_cnt  = work_cnt_q + (entry_i.ext ? CntW'(2 * SeptetW) : CntW'(SeptetW));
    cnt_after   = work_cnt_q - CntW'(8);
  end

  always_comb begin
    work_bits_d  = work_bits_q;
    work_cnt_d   = work_cnt_q;
    work_final_d = work_final_q;
    busy_d       = busy_q;
    entry_take_o = 1'b0;
    out_push     = 1'b0;
    out_word     = '{out_byte: work_bits_q[7:0], is_last: 1'b0, bad_char: 1'b0};
    if (busy_q) begin
      if (!out_full) begin
        out_push = 1'b1;
        if (work_cnt_q >= CntW'(8)) begin
          out_word.is_last = work_final_q && (work_cnt_q == CntW'(8));
          work_bits_d      = work_bits_q >> 8;
          work_cnt_d       = cnt_after;
          busy_d           = (cnt_after >= CntW'(8)) || (work_final_q && cnt_after != '0);
        end else begin
          if (work_cnt_q == CntW'(1)) begin
            out_word.out_byte = work_bits_q[7:0] | {CrSeptet, 1'b0};
          end
          out_word.is_last = 1'b1;
          work_bits_d      = '0;
          work_cnt_d       = '0;
          busy_d           = 1'b0;
        end
        if (!busy_d) begin
          work_final_d = 1'b0;
        end
      end
    end else if (entry_valid_i) begin
      if (entry_i.bad) begin
        if (!out_full) begin
          entry_take_o = 1'b1;
          out_push     = 1'b1;
          out_word     = '{out_byte: 8'h00, is_last: 1'b1, bad_char: 1'b1};
          work_bits_d  = '0;
          work_cnt_d   = '0;
        end
      end else begin
        entry_take_o = 1'b1;
        work_bits_d  = merged_bits;
        work_cnt_d   = merged_cnt;
        work_final_d = entry_i.final_char;
        busy_d       = (merged_cnt >= CntW'(8)) || entry_i.final_char;
      end
    end
  end

  always_comb begin
    out_wr_d  = out_push ? QPtrW'(out_wr_q + 1'b1) : out_wr_q;
    out_rd_d  = out_pop ? QPtrW'(out_rd_q + 1'b1) : out_rd_q;
    out_cnt_d = out_cnt_q;
    if (out_push && !out_pop) begin
      out_cnt_d = QCntW'(out_cnt_q + 1'b1);
    end else if (out_pop && !out_push) begin
      out_cnt_d = QCntW'(out_cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_bits_q  <= '0;
      work_cnt_q   <= '0;
      work_final_q <= 1'b0;
      busy_q       <= 1'b0;
      out_wr_q     <= '0;
      out_rd_q     <= '0;
      out_cnt_q    <= '0;
    end else begin
      work_bits_q  <= work_bits_d;
      work_cnt_q   <= work_cnt_d;
      work_final_q <= work_final_d;
      busy_q       <= busy_d;
      out_wr_q     <= out_wr_d;
      out_rd_q     <= out_rd_d;
      out_cnt_q    <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_mem_q[out_wr_q] <= out_word;
    end
  end

  // Between characters fewer than eight bits may wait.
  `GSP_ASSERT(a_idle_pending, !busy_q |-> (work_cnt_q < CntW'(8)), "pending bits overflow")
  `GSP_ASSERT(a_work_bound, work_cnt_q <= CntW'(WorkW), "work count out of range")
  `GSP_ASSERT_NEVER(a_push_full, out_push && out_full, "word written into a full queue")
  `GSP_ASSERT_NEVER(a_take_busy, entry_take_o && busy_q, "character taken while packing")
  `GSP_ASSERT(a_last_clears, (out_push && out_word.is_last) |=> (work_cnt_q == '0),
              "state not cleared after the last word")

endmodule

// File: hw/rtl/gsm7_septet_packer.sv
// GSM-7 septet packer: ASCII characters in, packed GSM-7 octets out. Each
// character enters a two-entry queue and is mapped to its septet there; the
// packer takes a character only while idle and then writes one octet per
// cycle into its two-word result queue while that queue is not full; it
// takes no new character until its pending octets are written. An extension
// character is sent as escape plus septet, a final character flushes the
// partial octet (adding CR when a single bit is left) and marks it last, and
// an unknown character gives one error word with is_last and bad_char set and
// starts a new message.
module gsm7_septet_packer import gsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code_i,
  input  logic       is_final_char_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       is_last_o,
  output logic       bad_char_o
);

  logic        entry_valid;
  logic        entry_take;
  sept_entry_t entry;
  out_word_t   word;

  gsp_front u_front (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .char_code_i,
    .is_final_char_i,
    .entry_valid_o (entry_valid),
    .entry_o       (entry),
    .entry_take_i  (entry_take)
  );

  gsp_back u_back (
    .clk_i,
    .rst_ni,
    .entry_valid_i (entry_valid),
    .entry_i       (entry),
    .entry_take_o  (entry_take),
    .empty,
    .pop,
    .word_o        (word)
  );

  assign out_byte_o = word.out_byte;
  assign is_last_o  = word.is_last;
  assign bad_char_o = word.bad_char;

endmodule
